>>> rtl/core/lmwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwf_pkg
// shared types, register indexes and defaults of the label majority filter
// ----------------------------------------------------------------------------
package lmwf_pkg;

    // fixed field widths
    localparam int FW_BITS       = 12;
    localparam int FH_BITS       = 16;
    localparam int WS_BITS       = 3;
    localparam int LBL_BITS      = 16;
    localparam int CNT_BITS      = 28;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_WINDOW = 7;
    localparam int DEF_LABEL_BITS = 16;

    // register indexes
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_FRAME_WIDTH  = 3'd0;
    localparam t_cfg_idx REG_FRAME_HEIGHT = 3'd1;
    localparam t_cfg_idx REG_WINDOW_SIZE  = 3'd2;
    localparam t_cfg_idx REG_USE_NODATA   = 3'd3;
    localparam t_cfg_idx REG_NODATA_VALUE = 3'd4;

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [LBL_BITS-1:0] pixel_label;
    } t_in;

    typedef struct packed {
        logic [LBL_BITS-1:0] filtered_label;
        logic                frame_end;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_DECIDE,
        ST_GATHER,
        ST_FLUSH,
        ST_COUNT,
        ST_FINAL,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_item;
        logic store_px;
        logic gather_init;
        logic gather_step;
        logic count_init;
        logic count_step;
        logic load_result;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic px_ok;
        logic release_ok;
        logic gather_last;
        logic count_last;
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/lmwf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwf_ctrl
// sequencer: store, release check, window gather, vote count, result transfer
// ----------------------------------------------------------------------------
module lmwf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output lmwf_pkg::t_cmd    o_cmd,
    input  lmwf_pkg::t_status i_status
);
    import lmwf_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.store_px = i_status.px_ok;
                n_state        = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.release_ok) begin
                    o_cmd.gather_init = 1'b1;
                    n_state           = ST_GATHER;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_GATHER: begin
                o_cmd.gather_step = 1'b1;
                if (i_status.gather_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                o_cmd.count_init = 1'b1;
                n_state          = ST_COUNT;
            end
            ST_COUNT: begin
                o_cmd.count_step = 1'b1;
                if (i_status.count_last) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/lmwf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwf_datapath
// row store, frame counters, window gather lanes, vote counter, output register
// ----------------------------------------------------------------------------
module lmwf_datapath #(
    parameter int MAX_WIDTH  = lmwf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = lmwf_pkg::DEF_MAX_WINDOW,
    parameter int LABEL_BITS = lmwf_pkg::DEF_LABEL_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  lmwf_pkg::t_in                           i_item,
    input  logic                                    i_cfg_we,
    input  lmwf_pkg::t_cfg_idx                      i_cfg_index,
    input  logic [lmwf_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  lmwf_pkg::t_cmd                          i_cmd,
    output lmwf_pkg::t_status                       o_status,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output lmwf_pkg::t_out                          o_out
);
    import lmwf_pkg::*;

    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = FW_BITS + 4;
    localparam int SW    = ((AW > OW) ? AW : OW) + 2;
    localparam int NV    = MAX_WINDOW * MAX_WINDOW;
    localparam int NCW   = $clog2(NV + 1);
    localparam int RW    = $clog2(NV);
    localparam logic [AW-1:0] DEPTH_M1 = AW'(DEPTH - 1);

    // configuration registers
    logic [FW_BITS-1:0]  r_fw;
    logic [FH_BITS-1:0]  r_fh;
    logic [WS_BITS-1:0]  r_ws;
    logic                r_use;
    logic [LBL_BITS-1:0] r_nd;

    // effective settings, registered
    logic [FW_BITS-1:0]    eff_w;
    logic [FH_BITS-1:0]    eff_h;
    logic [WS_BITS-1:0]    eff_k;
    logic [FW_BITS-1:0]    r_w;
    logic [FH_BITS-1:0]    r_h;
    logic [1:0]            r_half;
    logic [CNT_BITS-1:0]   r_total;
    logic [OW-1:0]         r_lag;
    logic [LABEL_BITS-1:0] r_nd_lbl;

    // frame counters and pointers
    logic [CNT_BITS-1:0] r_taken;
    logic [CNT_BITS-1:0] r_given;
    logic [AW-1:0]       r_wp;
    logic [AW-1:0]       r_qaddr;
    logic [FH_BITS-1:0]  r_qrow;
    logic [FW_BITS-1:0]  r_qcol;
    t_in                 r_item;

    // store
    logic [LABEL_BITS-1:0] mem [DEPTH];
    logic [LABEL_BITS-1:0] r_rd;
    logic [AW-1:0]         rd_addr;

    // gather walk
    logic signed [3:0]    r_dr;
    logic signed [3:0]    r_dc;
    logic signed [OW-1:0] r_off;
    logic signed [3:0]    hs;
    logic signed [SW-1:0] sum;
    logic signed [17:0]   rr;
    logic signed [13:0]   cc;
    logic                 in_row;
    logic                 in_col;
    logic                 r_p_act;
    logic                 r_p_ok;
    logic                 r_p_ctr;

    // vote lanes and count
    logic [LABEL_BITS-1:0] r_lane [NV];
    logic [NV-1:0]         r_lval;
    logic [LABEL_BITS-1:0] r_centre;
    logic [RW-1:0]         r_rot;
    logic [NCW-1:0]        cnt;
    logic                  r_st_v;
    logic [NCW-1:0]        r_st_cnt;
    logic [LABEL_BITS-1:0] r_st_lbl;
    logic [NCW-1:0]        r_best_cnt;
    logic [LABEL_BITS-1:0] r_best;
    logic [LABEL_BITS-1:0] res;
    logic                  frame_end_c;
    logic                  cfg_hit;
    t_out                  r_out;
    logic                  r_out_valid;

    function automatic logic non_voting(input logic [LABEL_BITS-1:0] v,
                                        input logic use_nd,
                                        input logic [LABEL_BITS-1:0] nd);
        non_voting = (v == '0) || (use_nd && (v == nd));
    endfunction

    assign cfg_hit = i_cfg_we && (i_cfg_index == REG_FRAME_WIDTH ||
                                  i_cfg_index == REG_FRAME_HEIGHT ||
                                  i_cfg_index == REG_WINDOW_SIZE ||
                                  i_cfg_index == REG_USE_NODATA ||
                                  i_cfg_index == REG_NODATA_VALUE);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= FW_BITS'(1);
            r_fh  <= FH_BITS'(1);
            r_ws  <= WS_BITS'(3);
            r_use <= 1'b0;
            r_nd  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_fw  <= i_cfg_data[FW_BITS-1:0];
                REG_FRAME_HEIGHT: r_fh  <= i_cfg_data[FH_BITS-1:0];
                REG_WINDOW_SIZE:  r_ws  <= i_cfg_data[WS_BITS-1:0];
                REG_USE_NODATA:   r_use <= i_cfg_data[0];
                REG_NODATA_VALUE: r_nd  <= i_cfg_data[LBL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp settings to their legal ranges
    always_comb begin
        eff_w = r_fw;
        if (r_fw == '0) begin
            eff_w = FW_BITS'(1);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            eff_w = FW_BITS'(MAX_WIDTH);
        end
        eff_h = (r_fh == '0) ? FH_BITS'(1) : r_fh;
        eff_k = r_ws;
        if (r_ws < WS_BITS'(3)) begin
            eff_k = WS_BITS'(3);
        end else if (32'(r_ws) > MAX_WINDOW) begin
            eff_k = WS_BITS'(MAX_WINDOW);
        end
        if (!eff_k[0]) begin
            eff_k = eff_k - WS_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_w      <= eff_w;
        r_h      <= eff_h;
        r_half   <= eff_k[2:1];
        r_total  <= CNT_BITS'(eff_w * eff_h);
        r_lag    <= OW'(eff_k[2:1] * eff_w) + OW'(eff_k[2:1]);
        r_nd_lbl <= LABEL_BITS'(r_nd);
    end

    // item register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_item <= i_item;
        end
    end

    assign frame_end_c = ({1'b0, r_given} + 1'b1) >= {1'b0, r_total};

    // frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_taken <= '0;
            r_given <= '0;
            r_wp    <= '0;
            r_qaddr <= '0;
            r_qrow  <= '0;
            r_qcol  <= '0;
        end else begin
            if (i_cmd.store_px) begin
                r_taken <= r_taken + 1'b1;
                r_wp    <= (r_wp == DEPTH_M1) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd.load_result) begin
                if (frame_end_c) begin
                    r_taken <= '0;
                    r_given <= '0;
                    r_wp    <= '0;
                    r_qaddr <= '0;
                    r_qrow  <= '0;
                    r_qcol  <= '0;
                end else begin
                    r_given <= r_given + 1'b1;
                    r_qaddr <= (r_qaddr == DEPTH_M1) ? '0 : r_qaddr + 1'b1;
                    if (r_qcol == r_w - 1'b1) begin
                        r_qcol <= '0;
                        r_qrow <= r_qrow + 1'b1;
                    end else begin
                        r_qcol <= r_qcol + 1'b1;
                    end
                end
            end
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_px) begin
            mem[r_wp] <= LABEL_BITS'(r_item.pixel_label);
        end
        r_rd <= mem[rd_addr];
    end

    // window address with wrap around the circular store
    assign hs  = $signed({2'b00, r_half});
    assign sum = $signed(SW'({1'b0, r_qaddr})) + SW'(r_off);
    always_comb begin
        if (sum < 0) begin
            rd_addr = AW'(sum + SW'(DEPTH));
        end else if (sum >= SW'(DEPTH)) begin
            rd_addr = AW'(sum - SW'(DEPTH));
        end else begin
            rd_addr = AW'(sum);
        end
    end

    // border clipping
    assign rr     = $signed({2'b00, r_qrow}) + 18'(r_dr);
    assign cc     = $signed({2'b00, r_qcol}) + 14'(r_dc);
    assign in_row = !rr[17] && (rr[16:0] < {1'b0, r_h});
    assign in_col = !cc[13] && (cc[12:0] < {1'b0, r_w});

    // gather walk over the window
    always_ff @(posedge i_clk) begin
        if (i_cmd.gather_init) begin
            r_dr  <= -hs;
            r_dc  <= -hs;
            r_off <= -$signed(r_lag);
        end else if (i_cmd.gather_step) begin
            if (r_dc == hs) begin
                r_dc  <= -hs;
                r_dr  <= r_dr + 4'sd1;
                r_off <= r_off + $signed(OW'(r_w)) - $signed(OW'({r_half, 1'b0}));
            end else begin
                r_dc  <= r_dc + 4'sd1;
                r_off <= r_off + OW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_act <= 1'b0;
        end else begin
            r_p_act <= i_cmd.gather_step;
        end
        r_p_ok  <= in_row && in_col;
        r_p_ctr <= (r_dr == 4'sd0) && (r_dc == 4'sd0);
    end

    // vote lanes: shift in while gathering, rotate while counting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.gather_init) begin
            r_lval <= '0;
        end else if (r_p_act) begin
            r_lval <= {r_lval[NV-2:0], r_p_ok && !non_voting(r_rd, r_use, r_nd_lbl)};
        end else if (i_cmd.count_step) begin
            r_lval <= {r_lval[NV-2:0], r_lval[NV-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_act) begin
            r_lane[0] <= r_rd;
            for (int i = 1; i < NV; i++) begin
                r_lane[i] <= r_lane[i-1];
            end
            if (r_p_ctr) begin
                r_centre <= r_rd;
            end
        end else if (i_cmd.count_step) begin
            r_lane[0] <= r_lane[NV-1];
            for (int i = 1; i < NV; i++) begin
                r_lane[i] <= r_lane[i-1];
            end
        end
    end

    // matches of the head lane across all lanes
    always_comb begin
        cnt = '0;
        for (int i = 0; i < NV; i++) begin
            cnt = cnt + NCW'(r_lval[i] && (r_lane[i] == r_lane[NV-1]));
        end
    end

    // count stage and running best
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_v <= 1'b0;
        end else begin
            r_st_v <= i_cmd.count_step && r_lval[NV-1];
        end
        r_st_cnt <= cnt;
        r_st_lbl <= r_lane[NV-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.count_init) begin
            r_rot      <= '0;
            r_best_cnt <= '0;
        end else begin
            if (i_cmd.count_step) begin
                r_rot <= r_rot + 1'b1;
            end
            if (r_st_v && (r_st_cnt > r_best_cnt ||
                           (r_st_cnt == r_best_cnt && r_st_lbl < r_best))) begin
                r_best_cnt <= r_st_cnt;
                r_best     <= r_st_lbl;
            end
        end
    end

    assign res = non_voting(r_centre, r_use, r_nd_lbl) ? r_centre : r_best;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_result) begin
            r_out.filtered_label <= LBL_BITS'(res);
            r_out.frame_end      <= frame_end_c;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // status
    assign o_status.px_ok       = (r_item.cmd == CMD_PIXEL) && (r_taken < r_total);
    assign o_status.release_ok  = (r_given < r_taken) &&
                                  ((r_taken >= r_total) ||
                                   (({1'b0, r_given} + (CNT_BITS+1)'(r_lag)) <
                                    {1'b0, r_taken}));
    assign o_status.gather_last = (r_dr == hs) && (r_dc == hs);
    assign o_status.count_last  = (r_rot == RW'(NV - 1));
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

endmodule

>>> rtl/core/label_majority_window_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_majority_window_filter_top
// k by k majority (mode) filter over a label raster, border clipped
// ----------------------------------------------------------------------------
// an item with no result passes IDLE, WRITE and DECIDE; one that releases a result
//   also walks GATHER, FLUSH, COUNT, FINAL and DONE
// a result's cost is set by the one-read-a-cycle window gather from the row store
//   and the vote count that rotates through all MAX_WINDOW*MAX_WINDOW lanes
// one item in flight; a finished result waits in the output register
// synchronous active-low reset restores register defaults and an empty frame
// ----------------------------------------------------------------------------
module label_majority_window_filter_top #(
    parameter int MAX_WIDTH  = lmwf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = lmwf_pkg::DEF_MAX_WINDOW,
    parameter int LABEL_BITS = lmwf_pkg::DEF_LABEL_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  lmwf_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output lmwf_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  lmwf_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [lmwf_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import lmwf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // configuration always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    lmwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // datapath
    lmwf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW),
        .LABEL_BITS (LABEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out_data)
    );

endmodule

>>> rtl/core/lmwf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwf_checker
// port-level checks of the majority filter, bound to the top level
// ----------------------------------------------------------------------------
module lmwf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input lmwf_pkg::t_out o_out_data,
    input logic           o_out_valid,
    input logic           i_out_stall
);

    // held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // held result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // one item in flight: input closes after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // reset leaves no result and an open input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset state wrong");

endmodule

bind label_majority_window_filter_top lmwf_checker u_lmwf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_data  (o_out_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

>>> tb/lmwf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwf_scoreboard
// watches the filter's channels, predicts each filtered label and compares
// ----------------------------------------------------------------------------
module lmwf_scoreboard (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  lmwf_pkg::t_in                      i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  lmwf_pkg::t_out                     i_out_data,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  lmwf_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [lmwf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_results,
    output int                                 o_frames
);
    import lmwf_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_WINDOW * DEF_MAX_WIDTH;

    // shadow of the pixel store and the frame counters
    logic [LBL_BITS-1:0] pix_mem [STORE_DEPTH];
    int unsigned taken_cnt, given_cnt;
    logic [FW_BITS-1:0]  width_reg;
    logic [FH_BITS-1:0]  height_reg;
    logic [WS_BITS-1:0]  win_reg;
    logic                nodata_en;
    logic [LBL_BITS-1:0] nodata_lbl;
    t_out                label_fifo [$];

    function automatic bit is_mute(logic [LBL_BITS-1:0] v);
        return v == '0 || (nodata_en && v == nodata_lbl);
    endfunction

    // mode over the border-clipped window, ties to the smaller label
    function automatic logic [LBL_BITS-1:0] majority_label(int unsigned q,
            int unsigned w, int unsigned h, int unsigned half);
        logic [LBL_BITS-1:0] votes [$];
        logic [LBL_BITS-1:0] centre, best, v;
        int unsigned r, c, r0, r1, c0, c1, cnt, best_cnt;
        r = q / w;
        c = q % w;
        r0 = (r >= half) ? r - half : 0;
        r1 = (r + half < h) ? r + half : h - 1;
        c0 = (c >= half) ? c - half : 0;
        c1 = (c + half < w) ? c + half : w - 1;
        centre = pix_mem[q % STORE_DEPTH];
        best = centre;
        best_cnt = 0;
        if (is_mute(centre)) return centre;
        for (int unsigned rr = r0; rr <= r1; rr++)
            for (int unsigned cc = c0; cc <= c1; cc++) begin
                v = pix_mem[(rr * w + cc) % STORE_DEPTH];
                if (!is_mute(v)) votes = {votes, v};
            end
        foreach (votes[i]) begin
            cnt = 0;
            foreach (votes[j]) if (votes[j] == votes[i]) cnt++;
            if (cnt > best_cnt || (cnt == best_cnt && votes[i] < best)) begin
                best_cnt = cnt;
                best = votes[i];
            end
        end
        return best;
    endfunction

    // advance the frame model by one accepted item
    task automatic filter_item(t_in it);
        int unsigned w, h, k, half, total, lag;
        t_out res;
        w = (width_reg == 0) ? 1 : width_reg;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        h = (height_reg == 0) ? 1 : height_reg;
        k = win_reg;
        if (k < 3) k = 3;
        if (k > DEF_MAX_WINDOW) k = DEF_MAX_WINDOW;
        if (k % 2 == 0) k = k - 1;
        half = k / 2;
        total = w * h;
        lag = half * w + half;
        if (it.cmd == CMD_PIXEL && taken_cnt < total) begin
            pix_mem[taken_cnt % STORE_DEPTH] = it.pixel_label;
            taken_cnt++;
        end
        if (given_cnt < taken_cnt && (taken_cnt >= total || given_cnt + lag < taken_cnt)) begin
            res.filtered_label = majority_label(given_cnt, w, h, half);
            res.frame_end = (given_cnt + 1 >= total);
            label_fifo = {label_fifo, res};
            if (res.frame_end) begin
                taken_cnt = 0;
                given_cnt = 0;
            end else begin
                given_cnt++;
            end
        end
    endtask

    assign o_pending = label_fifo.size();

    // observe transfers on all three channels
    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            taken_cnt = 0;
            given_cnt = 0;
            width_reg = 1;
            height_reg = 1;
            win_reg = 3;
            nodata_en = 0;
            nodata_lbl = 0;
            label_fifo.delete();
            o_errors = 0;
            o_results = 0;
            o_frames = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  width_reg = i_cfg_data[FW_BITS-1:0];
                    REG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    REG_WINDOW_SIZE:  win_reg = i_cfg_data[WS_BITS-1:0];
                    REG_USE_NODATA:   nodata_en = i_cfg_data[0];
                    REG_NODATA_VALUE: nodata_lbl = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= REG_NODATA_VALUE) begin
                    taken_cnt = 0;
                    given_cnt = 0;
                end
            end
            if (i_in_valid && !i_in_stall) filter_item(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (label_fifo.size() == 0) begin
                    $error("unexpected result transfer %h", i_out_data);
                    o_errors++;
                end else begin
                    exp_res = label_fifo.pop_front();
                    o_results++;
                    if (exp_res.frame_end) o_frames++;
                    if (i_out_data.filtered_label !== exp_res.filtered_label) begin
                        $error("filtered_label expected %0d actual %0d",
                               exp_res.filtered_label, i_out_data.filtered_label);
                        o_errors++;
                    end
                    if (i_out_data.frame_end !== exp_res.frame_end) begin
                        $error("frame_end expected %0d actual %0d",
                               exp_res.frame_end, i_out_data.frame_end);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the label majority filter: directed frames, then random frames
// over several geometries and nodata settings, with bursty input and stalls
// ----------------------------------------------------------------------------
module tb_top;
    import lmwf_pkg::*;

    // index outside the register list
    localparam t_cfg_idx REG_UNLISTED = 3'd7;

    logic   i_clk, i_rst_n;
    logic   in_valid, in_stall, out_valid, out_stall;
    t_in    in_data;
    t_out   out_data;
    logic   cfg_valid, cfg_ready;
    t_cfg_idx cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int     errors, pending, results, frames;
    int     items_sent;

    label_majority_window_filter_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    lmwf_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_frames(frames)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stall pattern, with a long hold-off every few hundred items
    initial begin
        int mode;
        int hold_left;
        int next_hold;
        out_stall = 0;
        hold_left = 0;
        next_hold = 300;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && items_sent >= next_hold) begin
                hold_left = 400;
                next_hold = next_hold + 500;
            end
            if (hold_left > 0) begin
                out_stall <= 1;
                hold_left--;
            end else begin
                mode = (items_sent / 200) % 3;
                if (mode == 0) out_stall <= 0;
                else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
                else out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // one item transfer, with an occasional random gap first
    task automatic send_item(logic cmd, logic [LBL_BITS-1:0] lbl);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 6)) begin
                in_valid <= 0;
                @(negedge i_clk);
            end
        in_valid <= 1;
        in_data.cmd <= cmd;
        in_data.pixel_label <= lbl;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 0;
    endtask

    task automatic set_frame(int w, int h, int k, bit nd_en, logic [15:0] nd);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
        write_reg(REG_WINDOW_SIZE, CFG_DATA_BITS'(k));
        write_reg(REG_USE_NODATA, CFG_DATA_BITS'(nd_en));
        write_reg(REG_NODATA_VALUE, nd);
    endtask

    // label from a small palette so votes collide, sometimes nodata or full range
    function automatic logic [LBL_BITS-1:0] pick_label(logic [15:0] nd);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return nd;
            2: return LBL_BITS'($urandom_range(0, 65535));
            default: return LBL_BITS'($urandom_range(1, 4));
        endcase
    endfunction

    // a frame-sized run of items, mostly pixels with rare drains, then drains for the tail
    task automatic run_frame(int w, int h, logic [15:0] nd);
        for (int i = 0; i < w * h; i++)
            if ($urandom_range(0, 29) == 0) send_item(CMD_DRAIN, LBL_BITS'($urandom));
            else send_item(CMD_PIXEL, pick_label(nd));
        for (int i = 0; i < 3 * w + 4; i++) send_item(CMD_DRAIN, LBL_BITS'($urandom));
    endtask

    initial begin
        int w, h, k;
        logic [15:0] nd;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        items_sent = 0;
        i_rst_n = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: single pixel at reset defaults, extremes, drain with nothing
        send_item(CMD_DRAIN, 16'hffff);
        send_item(CMD_PIXEL, 16'hffff);
        send_item(CMD_PIXEL, 16'h0001);
        send_item(CMD_PIXEL, 16'h0000);
        settle();
        // zero sizes act as one, window extremes and even window
        set_frame(0, 0, 0, 1, 16'hffff);
        send_item(CMD_PIXEL, 16'hffff);
        send_item(CMD_PIXEL, 16'h8000);
        settle();
        set_frame(4, 3, 6, 1, 16'h0005);
        send_item(CMD_PIXEL, 5);
        for (int i = 0; i < 11; i++) send_item(CMD_PIXEL, (i % 3 == 0) ? 16'h7 : 16'h2);
        send_item(CMD_PIXEL, 9);
        for (int i = 0; i < 8; i++) send_item(CMD_DRAIN, 0);
        settle();
        // register write mid-frame aborts it; unlisted index does nothing
        set_frame(3, 3, 7, 0, 0);
        send_item(CMD_PIXEL, 3);
        send_item(CMD_PIXEL, 3);
        settle();
        write_reg(REG_UNLISTED, 16'hffff);
        write_reg(REG_FRAME_WIDTH, 16'hffff);
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 1);
        send_item(CMD_PIXEL, 4);
        send_item(CMD_PIXEL, 4);
        settle();

        // random frames, mostly small
        while (items_sent < 1500) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            k = $urandom_range(0, 7);
            nd = ($urandom_range(0, 1)) ? 16'($urandom_range(1, 4)) : 16'($urandom);
            set_frame(w, h, k, $urandom_range(0, 1), nd);
            run_frame(w, h, nd);
            settle();
        end

        $display("covered %0d items, %0d results over %0d frames",
                 items_sent, results, frames);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lmwf_pkg.sv
rtl/core/lmwf_ctrl.sv
rtl/core/lmwf_datapath.sv
rtl/core/label_majority_window_filter_top.sv
rtl/core/lmwf_checker.sv
tb/lmwf_checker.sv
tb/tb_top.sv
